FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the track converter.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a signal stays stable from one edge to the next when enabled.
`define ASSERT_HOLD(label, clk, rst_n, en, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) en |=> $stable(sig)) \
    else $error(msg);
`endif

FILE: hw/rtl/thfm_pkg.sv
// Shared types and constants of the track to four-momentum converter.
// Depends on nothing; used by the interfaces, the CORDIC cell, the top level and the testbench.
`default_nettype none
package thfm_pkg;
  localparam int unsigned TableLen = 24;
  localparam logic [31:0] FieldReset = 32'd4506596;
  localparam logic [39:0] MassReset = 40'd83665254;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef enum logic [0:0] {
    RegFieldConstant = 1'b0,
    RegMassSquared = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] curvature;
    logic signed [23:0] dip_tangent;
    logic [15:0] azimuth;
  } track_t;

  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [31:0] energy;
    logic charge_negative;
    logic saturated;
  } four_mom_t;

  typedef struct packed {
    logic [0:0] index;
    logic [39:0] data;
  } cfg_t;

  function automatic logic [31:0] turn_atan(input int unsigned i);
    logic [31:0] t [TableLen];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return (i < TableLen) ? t[i] : 32'd0;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/thfm_if.sv
// Valid/ready channels of the track converter: track, result and register write.
// Depends on thfm_pkg for the payload types.
`default_nettype none
interface thfm_track_if;
  logic valid;
  logic ready;
  thfm_pkg::track_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface thfm_result_if;
  logic valid;
  logic ready;
  thfm_pkg::four_mom_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface thfm_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [39:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/thfm_div_cell.sv
// One restoring-division cell: produces one quotient bit per pipeline step.
// Depends on nothing; chained by the top level to form the pT divider.
`default_nettype none
module thfm_div_cell #(
  parameter int unsigned NumW = 49,
  parameter int unsigned DenW = 32,
  parameter int unsigned Bit = 0,
  parameter int unsigned SideW = 8
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic [NumW-1:0] rem_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [NumW-1:0] quo_i,
  input  wire logic [SideW-1:0] side_i,
  output logic [NumW-1:0] rem_o,
  output logic [DenW-1:0] den_o,
  output logic [NumW-1:0] quo_o,
  output logic [SideW-1:0] side_o
);
  logic [NumW+DenW-1:0] sub;
  logic fits;
  always_comb begin
    sub = {{DenW{1'b0}}, rem_i} >> Bit;
    fits = (sub >= {{NumW{1'b0}}, den_i});
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      side_o <= side_i;
      if (fits) begin
        rem_o <= rem_i - NumW'({{NumW{1'b0}}, den_i} << Bit);
        quo_o <= quo_i | (NumW'(1) << Bit);
      end else begin
        rem_o <= rem_i;
        quo_o <= quo_i;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/thfm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent constant.
// Depends on thfm_pkg for the table; chained by the top level.
`default_nettype none
module thfm_cordic_cell #(
  parameter int unsigned Stage = 0,
  parameter int unsigned SideW = 8
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic signed [33:0] x_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] z_i,
  input  wire logic [SideW-1:0] side_i,
  output logic signed [33:0] x_o,
  output logic signed [33:0] y_o,
  output logic signed [33:0] z_o,
  output logic [SideW-1:0] side_o
);
  localparam logic signed [33:0] Atan = 34'(thfm_pkg::turn_atan(Stage));
  logic signed [33:0] dx, dy;
  always_comb begin
    dx = y_i >>> Stage;
    dy = x_i >>> Stage;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (!z_i[33]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - Atan;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + Atan;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/thfm_sqrt_cell.sv
// One digit-recurrence square-root cell: settles one result bit per step.
// Depends on nothing; chained by the top level to form the energy root.
`default_nettype none
module thfm_sqrt_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned SideW = 8
) (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  wire logic [63:0] v_i,
  input  wire logic [63:0] r_i,
  input  wire logic [SideW-1:0] side_i,
  output logic [63:0] v_o,
  output logic [63:0] r_o,
  output logic [SideW-1:0] side_o
);
  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Step);
  logic [64:0] trial;
  always_comb trial = {1'b0, r_i} + {1'b0, Bit};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if ({1'b0, v_i} >= trial) begin
        v_o <= v_i - trial[63:0];
        r_o <= (r_i >> 1) + Bit;
      end else begin
        v_o <= v_i;
        r_o <= r_i >> 1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/track_helix_to_four_momentum.sv
// Top level of the helix track to four-momentum converter.
// Depends on thfm_pkg, thfm_if, the three cell modules and assert_macros.svh.
// The block takes one track request per cycle while not stalled and returns one
// result request per track, in order. Tracks pass an input stage, (FRAC_BITS+32)
// divider cells, 2 product stages, 32 root cells and an output register; the
// CORDIC runs beside the divider. The whole pipeline advances only when its
// output register is free or taken, so a stalled output holds every stage.
`default_nettype none
`include "assert_macros.svh"
module track_helix_to_four_momentum #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  thfm_track_if.sink track_i,
  thfm_result_if.source result_o,
  thfm_cfg_if.sink cfg_i
);
  localparam int unsigned NumW = FRAC_BITS + 32;
  localparam int unsigned DivN = NumW;
  localparam int unsigned CorN = (CORDIC_STAGES < thfm_pkg::TableLen) ?
                                 CORDIC_STAGES : thfm_pkg::TableLen;
  localparam int unsigned SqN = 32;
  localparam int unsigned Lat = 1 + DivN + 2 + SqN + 1;
  localparam int signed Sh = 2 * FRAC_BITS - 32;

  logic [31:0] field_q;
  logic [39:0] mass_q;
  logic en;
  logic [Lat-1:0] vld_q;

  assign en = !result_o.valid || result_o.ready;
  assign track_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= thfm_pkg::FieldReset;
      mass_q <= thfm_pkg::MassReset;
      vld_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          thfm_pkg::RegFieldConstant: field_q <= cfg_i.data[31:0];
          thfm_pkg::RegMassSquared: mass_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (en) vld_q <= {vld_q[Lat-2:0], track_i.valid};
    end
  end
  assign result_o.valid = vld_q[Lat-1];

  // Stage 0: magnitudes, signs, phase setup.
  localparam int unsigned SideW = 24 + 1 + 1 + 1 + 1;
  logic [NumW-1:0] num_s0;
  logic [31:0] den_s0;
  logic [SideW-1:0] side_s0;
  logic signed [33:0] cx_s0, cy_s0, cz_s0;
  logic flip_s0;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [31:0] om, ph;
      logic [23:0] td;
      logic fl;
      om = track_i.data.curvature[31] ? 32'(-track_i.data.curvature) :
           32'(track_i.data.curvature);
      td = track_i.data.dip_tangent[23] ? 24'(-track_i.data.dip_tangent) :
           24'(track_i.data.dip_tangent);
      ph = 32'({16'd0, track_i.data.azimuth} & ((32'd1 << ANGLE_BITS) - 32'd1))
           << (32 - ANGLE_BITS);
      fl = ph[31] ^ ph[30];
      if (fl) ph = ph - 32'h80000000;
      num_s0 <= NumW'({field_q, {FRAC_BITS{1'b0}}});
      den_s0 <= om;
      side_s0 <= {td, track_i.data.dip_tangent[23], !track_i.data.curvature[31],
                  om == 32'd0, fl};
      cx_s0 <= thfm_pkg::GainQ30;
      cy_s0 <= '0;
      cz_s0 <= 34'(signed'(ph));
    end
  end

  // Divider chain, quotient bits from the top down.
  logic [NumW-1:0] rem_c [DivN+1];
  logic [NumW-1:0] quo_c [DivN+1];
  logic [31:0] den_c [DivN+1];
  logic [SideW-1:0] side_c [DivN+1];
  assign rem_c[0] = num_s0;
  assign quo_c[0] = '0;
  assign den_c[0] = den_s0;
  assign side_c[0] = side_s0;
  for (genvar g = 0; g < DivN; g++) begin : g_div
    thfm_div_cell #(.NumW(NumW), .DenW(32), .Bit(DivN - 1 - g), .SideW(SideW)) u_cell (
      .clk_i, .en_i(en), .rem_i(rem_c[g]), .den_i(den_c[g]), .quo_i(quo_c[g]),
      .side_i(side_c[g]), .rem_o(rem_c[g+1]), .den_o(den_c[g+1]),
      .quo_o(quo_c[g+1]), .side_o(side_c[g+1]));
  end

  // CORDIC chain, then delay to match the divider.
  logic signed [33:0] x_c [CorN+1];
  logic signed [33:0] y_c [CorN+1];
  logic signed [33:0] z_c [CorN+1];
  logic [0:0] f_c [CorN+1];
  assign x_c[0] = cx_s0;
  assign y_c[0] = cy_s0;
  assign z_c[0] = cz_s0;
  assign f_c[0] = flip_s0;
  assign flip_s0 = side_s0[0];
  for (genvar g = 0; g < CorN; g++) begin : g_cor
    thfm_cordic_cell #(.Stage(g), .SideW(1)) u_cell (
      .clk_i, .en_i(en), .x_i(x_c[g]), .y_i(y_c[g]), .z_i(z_c[g]), .side_i(f_c[g]),
      .x_o(x_c[g+1]), .y_o(y_c[g+1]), .z_o(z_c[g+1]), .side_o(f_c[g+1]));
  end
  logic signed [33:0] cos_d [DivN-CorN+1];
  logic signed [33:0] sin_d [DivN-CorN+1];
  always_comb begin
    cos_d[0] = f_c[CorN][0] ? -x_c[CorN] : x_c[CorN];
    sin_d[0] = f_c[CorN][0] ? -y_c[CorN] : y_c[CorN];
  end
  for (genvar g = 0; g < DivN - CorN; g++) begin : g_cdly
    always_ff @(posedge clk_i) begin
      if (en) begin
        cos_d[g+1] <= cos_d[g];
        sin_d[g+1] <= sin_d[g];
      end
    end
  end

  // Product stage A: pT clip and the three products.
  logic [31:0] pt_a;
  logic [63:0] px_a, py_a, pz_a;
  logic cn_a, sn_a, tn_a, ch_a, sat_a;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [SideW-1:0] sd;
      logic [NumW-1:0] q;
      logic [31:0] pt;
      logic ovf;
      logic [33:0] cm, sm;
      sd = side_c[DivN];
      q = quo_c[DivN];
      ovf = sd[1] || (q > NumW'(64'hFFFFFFFF));
      pt = ovf ? 32'hFFFFFFFF : q[31:0];
      cm = cos_d[DivN-CorN][33] ? 34'(-cos_d[DivN-CorN]) : cos_d[DivN-CorN];
      sm = sin_d[DivN-CorN][33] ? 34'(-sin_d[DivN-CorN]) : sin_d[DivN-CorN];
      pt_a <= pt;
      px_a <= 64'(pt) * 64'(cm[32:0]);
      py_a <= 64'(pt) * 64'(sm[32:0]);
      pz_a <= 64'(pt) * 64'(sd[27:4]);
      cn_a <= cos_d[DivN-CorN][33];
      sn_a <= sin_d[DivN-CorN][33];
      tn_a <= sd[3];
      ch_a <= sd[2];
      sat_a <= ovf;
    end
  end

  // Product stage B: rounding, packing, squares, energy argument.
  logic [63:0] arg_b;
  logic big_b;
  logic [31:0] ox_b, oy_b, oz_b;
  logic ch_b, sat_b;
  function automatic logic [32:0] pack(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h80000000) return {1'b1, 32'h80000000};
      return {1'b0, 32'(64'h100000000 - mag)};
    end
    if (mag > 64'h7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
    return {1'b0, mag[31:0]};
  endfunction
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [63:0] mx, my, mz, m2;
      logic [32:0] kx, ky, kz;
      logic [65:0] s1, s2;
      mx = 64'((65'(px_a) + 65'(64'd1 << 29)) >> 30);
      my = 64'((65'(py_a) + 65'(64'd1 << 29)) >> 30);
      mz = 64'((65'(pz_a) + 65'(64'd1 << 15)) >> 16);
      kx = pack(cn_a, mx);
      ky = pack(sn_a, my);
      kz = pack(tn_a, mz);
      m2 = (Sh >= 0) ? (64'(mass_q) << Sh) : (64'(mass_q) >> (-Sh));
      s1 = 66'(64'(pt_a) * 64'(pt_a)) + 66'(64'(mz[31:0]) * 64'(mz[31:0]));
      s2 = s1 + 66'(m2);
      ox_b <= kx[31:0];
      oy_b <= ky[31:0];
      oz_b <= kz[31:0];
      big_b <= (mz > 64'hFFFFFFFF) || (s2[65:64] != 2'd0);
      arg_b <= s2[63:0];
      ch_b <= ch_a;
      sat_b <= sat_a | kx[32] | ky[32] | kz[32];
    end
  end

  // Root chain, carrying the other fields alongside.
  localparam int unsigned RW = 96 + 3;
  logic [63:0] v_c [SqN+1];
  logic [63:0] r_c [SqN+1];
  logic [RW-1:0] rs_c [SqN+1];
  assign v_c[0] = arg_b;
  assign r_c[0] = '0;
  assign rs_c[0] = {ox_b, oy_b, oz_b, ch_b, sat_b, big_b};
  for (genvar g = 0; g < SqN; g++) begin : g_sq
    thfm_sqrt_cell #(.Step(g), .SideW(RW)) u_cell (
      .clk_i, .en_i(en), .v_i(v_c[g]), .r_i(r_c[g]), .side_i(rs_c[g]),
      .v_o(v_c[g+1]), .r_o(r_c[g+1]), .side_o(rs_c[g+1]));
  end

  thfm_pkg::four_mom_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [RW-1:0] sd;
      sd = rs_c[SqN];
      res_q.mom_x <= sd[98:67];
      res_q.mom_y <= sd[66:35];
      res_q.mom_z <= sd[34:3];
      res_q.charge_negative <= sd[2];
      res_q.saturated <= sd[1] | sd[0];
      res_q.energy <= sd[0] ? 32'hFFFFFFFF : r_c[SqN][31:0];
    end
  end
  assign result_o.data = res_q;

  `ASSERT_IMPL(a_ready_when_free, clk_i, rst_ni, !result_o.valid |-> track_i.ready,
               "input stalled while output empty")
  `ASSERT_HOLD(a_hold_stalled, clk_i, rst_ni, result_o.valid && !result_o.ready,
               vld_q, "pipeline moved while output stalled")
  `ASSERT_IMPL(a_known_result, clk_i, rst_ni,
               result_o.valid |-> !$isunknown(result_o.data),
               "result request carries unknown bits")
endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of track_helix_to_four_momentum: sends directed and random tracks
// under several register settings, predicts each four-momentum and compares it field by field.
// Depends on thfm_pkg, thfm_if and the converter RTL.
`timescale 1ns / 1ps
module tb;
  localparam int Latency = 84;
  localparam logic [31:0] AtanTurn [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  thfm_track_if trk ();
  thfm_result_if res ();
  thfm_cfg_if cfg ();

  track_helix_to_four_momentum dut (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .track_i (trk),
    .result_o (res),
    .cfg_i (cfg)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0] field_k = thfm_pkg::FieldReset;
  logic [39:0] mass_sq = thfm_pkg::MassReset;
  thfm_pkg::four_mom_t expected_moms[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  initial begin
    trk.valid = 1'b0;
    trk.data = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = thfm_pkg::RegFieldConstant;
    cfg.data = '0;
  end

  function automatic logic [31:0] clip_signed(bit neg, logic [63:0] mag, inout bit sat);
    if (neg) begin
      if (mag > 64'h80000000) begin
        sat = 1'b1;
        mag = 64'h80000000;
      end
      return 32'(64'h100000000 - mag);
    end
    if (mag > 64'h7FFFFFFF) begin
      sat = 1'b1;
      mag = 64'h7FFFFFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r[31:0];
  endfunction

  function automatic thfm_pkg::four_mom_t four_momentum(thfm_pkg::track_t t);
    thfm_pkg::four_mom_t m;
    logic [31:0] om_raw;
    logic [23:0] td_raw;
    logic [63:0] om_mag, td_mag, pt, pz_mag, cm, sm, sum, sq;
    logic [65:0] total;
    logic [31:0] phase;
    longint x, y, z, dx, dy;
    bit flip, om_neg, td_neg, sat;
    om_raw = t.curvature;
    td_raw = t.dip_tangent;
    om_neg = om_raw[31];
    td_neg = td_raw[23];
    om_mag = om_neg ? 64'h100000000 - om_raw : 64'(om_raw);
    td_mag = td_neg ? 64'h1000000 - td_raw : 64'(td_raw);
    sat = 1'b0;
    if (om_mag == 0) begin
      pt = 64'hFFFFFFFF;
      sat = 1'b1;
    end else begin
      pt = (64'(field_k) << 16) / om_mag;
      if (pt > 64'hFFFFFFFF) begin
        pt = 64'hFFFFFFFF;
        sat = 1'b1;
      end
    end
    phase = {t.azimuth, 16'h0};
    flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
    if (flip) phase = phase - 32'h80000000;
    z = longint'($signed(phase));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(AtanTurn[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(AtanTurn[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cm = x < 0 ? -x : x;
    sm = y < 0 ? -y : y;
    m.mom_x = clip_signed(x < 0, (pt * cm + (64'd1 << 29)) >> 30, sat);
    m.mom_y = clip_signed(y < 0, (pt * sm + (64'd1 << 29)) >> 30, sat);
    pz_mag = (pt * td_mag + (64'd1 << 15)) >> 16;
    m.mom_z = clip_signed(td_neg, pz_mag, sat);
    if (pz_mag > 64'hFFFFFFFF) begin
      m.energy = 32'hFFFFFFFF;
      sat = 1'b1;
    end else begin
      sum = pt * pt;
      sq = pz_mag * pz_mag;
      total = 66'(sum) + 66'(sq) + 66'(mass_sq);
      if (total[65:64] != 0) begin
        m.energy = 32'hFFFFFFFF;
        sat = 1'b1;
      end else begin
        m.energy = root64(total[63:0]);
      end
    end
    m.charge_negative = !om_neg;
    m.saturated = sat;
    return m;
  endfunction

  // Result side: the ready pattern switches between modes after runs of random length.
  always @(negedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_count = $urandom_range(10, 80);
    end
    stall_count--;
    case (stall_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= $urandom_range(0, 1);
      2: res.ready <= ($urandom_range(0, 3) == 0);
      default: res.ready <= (stall_count % 16) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    thfm_pkg::four_mom_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_moms.size() == 0) begin
        $error("unexpected result request");
        errors++;
      end else begin
        e = expected_moms.pop_front();
        if (res.data.mom_x !== e.mom_x) begin
          $error("mom_x expected %h actual %h", e.mom_x, res.data.mom_x);
          errors++;
        end
        if (res.data.mom_y !== e.mom_y) begin
          $error("mom_y expected %h actual %h", e.mom_y, res.data.mom_y);
          errors++;
        end
        if (res.data.mom_z !== e.mom_z) begin
          $error("mom_z expected %h actual %h", e.mom_z, res.data.mom_z);
          errors++;
        end
        if (res.data.energy !== e.energy) begin
          $error("energy expected %h actual %h", e.energy, res.data.energy);
          errors++;
        end
        if (res.data.charge_negative !== e.charge_negative) begin
          $error("charge_negative expected %b actual %b", e.charge_negative,
                 res.data.charge_negative);
          errors++;
        end
        if (res.data.saturated !== e.saturated) begin
          $error("saturated expected %b actual %b", e.saturated, res.data.saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_track(thfm_pkg::track_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        trk.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    trk.valid <= 1'b1;
    trk.data <= t;
    do @(posedge clk_i); while (!trk.ready);
    expected_moms.push_back(four_momentum(t));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    trk.valid <= 1'b0;
    burst_left = 0;
    while (expected_moms.size() != 0) @(negedge clk_i);
    repeat (Latency + 16) @(negedge clk_i);
  endtask

  task automatic write_reg(thfm_pkg::reg_idx_e idx, logic [39:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx == thfm_pkg::RegFieldConstant) field_k = value[31:0];
    else mass_sq = value;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  function automatic thfm_pkg::track_t random_track();
    thfm_pkg::track_t t;
    logic [31:0] mag;
    mag = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 40) == 0) mag = '0;
    t.curvature = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    if ($urandom_range(0, 9) == 0) t.curvature = $urandom();
    t.dip_tangent = $urandom_range(0, 1) ? 24'($urandom()) :
                    24'($signed(24'($urandom_range(0, 262143)) - 24'd131072));
    t.azimuth = $urandom();
    return t;
  endfunction

  task automatic test_directed();
    thfm_pkg::track_t t;
    logic [31:0] om [8] = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                            32'd5000, 32'hFFFFEC78, 32'd12};
    logic [23:0] dt [8] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h010000,
                            24'hFF0000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF};
    logic [15:0] az [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                            16'hFFFF, 16'h3FFF, 16'h4001, 16'hBFFF};
    for (int i = 0; i < 8; i++) begin
      t.curvature = om[i];
      t.dip_tangent = dt[i];
      t.azimuth = az[i];
      send_track(t);
    end
    for (int i = 0; i < 8; i++) begin
      t.curvature = om[(i + 3) % 8];
      t.dip_tangent = dt[(i + 5) % 8];
      t.azimuth = az[i];
      send_track(t);
    end
  endtask

  task automatic test_random(int n);
    repeat (n) send_track(random_track());
  endtask

  task automatic test_pause();
    test_random(60);
    drain();
    test_random(60);
  endtask

  task automatic test_settings();
    write_reg(thfm_pkg::RegFieldConstant, 40'd0);
    write_reg(thfm_pkg::RegMassSquared, 40'd0);
    test_random(150);
    write_reg(thfm_pkg::RegFieldConstant, 40'hFFFFFFFF);
    write_reg(thfm_pkg::RegMassSquared, 40'hFFFFFFFFFF);
    test_random(200);
    write_reg(thfm_pkg::RegFieldConstant, 40'($urandom()));
    write_reg(thfm_pkg::RegMassSquared, {8'($urandom()), 32'($urandom())});
    test_random(200);
    write_reg(thfm_pkg::RegFieldConstant, 40'(thfm_pkg::FieldReset));
    write_reg(thfm_pkg::RegMassSquared, thfm_pkg::MassReset);
    test_random(150);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600);
    test_pause();
    test_settings();
    test_random(200);
    drain();
    if (errors == 0 && expected_moms.size() == 0) begin
      $display("** track_helix_to_four_momentum: PASSED **");
    end else begin
      $display("** track_helix_to_four_momentum: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** track_helix_to_four_momentum: FAILED **");
    $finish;
  end
endmodule
